@@ sv/asi_pkg.sv @@
// ----------------------------------------------------------------------------
// asi_pkg
// Shared types and constants for the argsort index sorter: input and result
// items, the queue entry between front and back, and one sorter cell.
// ----------------------------------------------------------------------------
package asi_pkg;

    localparam int KEY_W       = 32;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    // one list element as it arrives
    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    last_in;
    } t_in_item;

    // one result of a sorted run
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_out;
        logic             overflow;
    } t_out_item;

    // queue entry: the item plus the sort direction seen with it
    typedef struct packed {
        t_in_item item;
        logic     descending;
    } t_qentry;

    // one slot of a sorted row
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } t_cell;

endpackage

@@ sv/asi_front.sv @@
// ----------------------------------------------------------------------------
// asi_front
// Input side: holds the direction register, accepts items, tags each item
// with the current direction and keeps them in a short queue for the back.
// ----------------------------------------------------------------------------
module asi_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  asi_pkg::t_in_item i_item,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output asi_pkg::t_qentry o_q_head
);
    import asi_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic              r_descending;
    t_qentry           r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              push;
    logic              pop;

    // direction register; the user must write it only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (i_cfg_we) begin
            r_descending <= i_cfg_wdata;
        end
    end

    // handshakes
    assign o_ready   = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_fill != '0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_head  = r_slot[r_rd];

    always_comb begin
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_fill <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= '{item: i_item, descending: r_descending};
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_fill != '0))
        else $error("pop from empty queue");

    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("fill level lost a push");
`endif

endmodule

@@ sv/asi_back.sv @@
// ----------------------------------------------------------------------------
// asi_back
// Sort engine: two rows of cells in stable ascending and descending order,
// one insertion per cycle while filling; on the closing item the chosen row
// shifts out via an output register, one position per cycle unless stalled.
// ----------------------------------------------------------------------------
module asi_back #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  asi_pkg::t_qentry   i_q_head,
    output logic               o_valid,
    input  logic               i_ready,
    output asi_pkg::t_out_item o_item
);
    import asi_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic ST_FILL = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_remain;
    logic             r_dropped;
    logic             r_desc;
    logic             r_out_valid;
    t_out_item        r_out;

    t_cell r_asc [MAX_ITEMS];
    t_cell r_dsc [MAX_ITEMS];
    t_cell w_asc_up [MAX_ITEMS];
    t_cell w_dsc_up [MAX_ITEMS];
    t_cell w_asc_dn [MAX_ITEMS];
    t_cell w_dsc_dn [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] s_asc;
    logic [MAX_ITEMS-1:0] s_dsc;
    logic [MAX_ITEMS-1:0] w_asc_prev;
    logic [MAX_ITEMS-1:0] w_dsc_prev;

    t_cell new_cell;
    logic  pop;
    logic  has_room;
    logic  ins;
    logic  emit_load;

    assign o_q_ready = (r_state == ST_FILL);
    assign pop       = i_q_valid && o_q_ready;
    assign has_room  = (r_count < CNT_W'(MAX_ITEMS));
    assign ins       = pop && has_room;
    assign emit_load = (r_state == ST_EMIT) && (!r_out_valid || i_ready);
    assign new_cell  = '{key: i_q_head.item.value, pos: POS_W'(r_count)};

    // per cell: free slot or a key that the new one goes before
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            s_asc[i] = (CNT_W'(i) >= r_count) || (r_asc[i].key > new_cell.key);
            s_dsc[i] = (CNT_W'(i) >= r_count) || (r_dsc[i].key < new_cell.key);
        end
    end

    // neighbor wiring of the rows
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_nbr
        if (g == MAX_ITEMS - 1) begin : g_top
            assign w_asc_up[g] = r_asc[g];
            assign w_dsc_up[g] = r_dsc[g];
        end else begin : g_mid
            assign w_asc_up[g] = r_asc[g+1];
            assign w_dsc_up[g] = r_dsc[g+1];
        end
        if (g == 0) begin : g_bot
            assign w_asc_dn[g]   = new_cell;
            assign w_dsc_dn[g]   = new_cell;
            assign w_asc_prev[g] = 1'b0;
            assign w_dsc_prev[g] = 1'b0;
        end else begin : g_low
            assign w_asc_dn[g]   = r_asc[g-1];
            assign w_dsc_dn[g]   = r_dsc[g-1];
            assign w_asc_prev[g] = s_asc[g-1];
            assign w_dsc_prev[g] = s_dsc[g-1];
        end
    end

    // cells: shift down on emit, open a gap and insert on a new item
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (emit_load) begin
                r_asc[i] <= w_asc_up[i];
                r_dsc[i] <= w_dsc_up[i];
            end else if (ins) begin
                if (s_asc[i]) begin
                    r_asc[i] <= w_asc_prev[i] ? w_asc_dn[i] : new_cell;
                end
                if (s_dsc[i]) begin
                    r_dsc[i] <= w_dsc_prev[i] ? w_dsc_dn[i] : new_cell;
                end
            end
        end
    end

    // control: fill, then emit the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_count   <= '0;
            r_remain  <= '0;
            r_dropped <= 1'b0;
            r_desc    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (pop) begin
                        if (has_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_q_head.item.last_in) begin
                            r_state  <= ST_EMIT;
                            r_desc   <= i_q_head.descending;
                            r_remain <= has_room ? r_count + CNT_W'(1) : r_count;
                        end
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_remain <= r_remain - CNT_W'(1);
                        if (r_remain == CNT_W'(1)) begin
                            r_state   <= ST_FILL;
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out.position <= r_desc ? r_dsc[0].pos : r_asc[0].pos;
            r_out.last_out <= (r_remain == CNT_W'(1));
            r_out.overflow <= r_dropped;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("item count above capacity");

    a_emit_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ((r_remain != '0) && (r_remain <= r_count)))
        else $error("emit count out of range");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && (r_remain == CNT_W'(1)))
            |=> ((r_state == ST_FILL) && (r_count == '0) && !r_dropped))
        else $error("run end did not restart the list");

    a_rows_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FILL) && (r_count >= CNT_W'(2)))
            |-> ((r_asc[0].key <= r_asc[1].key) && (r_dsc[0].key >= r_dsc[1].key)))
        else $error("sorted rows out of order");
`endif

endmodule

@@ sv/argsort_index_sorter.sv @@
// ----------------------------------------------------------------------------
// argsort_index_sorter
// Stable argsort of a list of signed 32-bit keys, emitting arrival positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_item): one key per item; the item with
//   last_in set closes the list. Up to MAX_ITEMS keys are kept, later ones are
//   dropped and flagged with overflow on every result of that run.
//   Output channel (o_valid/i_ready, o_item): one result per stored key, the
//   arrival positions in sorted order, last_out on the final one.
//   Config: i_cfg_we/i_cfg_wdata set the direction (1 = descending); it is
//   captured with each item, so the closing item's value decides the run.
// Timing:
//   Each key passes through the input queue before it is inserted into the
//   sorted rows; the rows insert one key per cycle while filling. Once the
//   closing item is inserted, results leave through the output register,
//   one result per cycle while the receiver is ready. A list of n keys takes
//   n insertions plus n results. While results are being sent, two more
//   items fit in the input queue, then o_ready drops until the run is done.
// Reset:
//   Synchronous, active low; clears the list, the queue and the direction.
//   A stalled receiver simply holds the current result and pauses the run.
// ----------------------------------------------------------------------------
module argsort_index_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  asi_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output asi_pkg::t_out_item o_item
);
    import asi_pkg::*;

    logic    q_valid;
    logic    q_ready;
    t_qentry q_head;

    asi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_head    (q_head)
    );

    asi_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_head  (q_head),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

@@ sim/tb_argsort_index_sorter.sv @@
// ----------------------------------------------------------------------------
// tb_argsort_index_sorter
// Self-checking bench for the stable argsort block. A short directed table
// covers key extremes, ties in both directions and one-key lists. Random lists
// follow, including full and overflowing lists. Every result is compared with
// a behavioral sort of the same keys, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_argsort_index_sorter;
    import asi_pkg::*;

    localparam int   LIST_CAP         = 64;
    localparam logic ASCENDING        = 1'b0;
    localparam logic DESCENDING       = 1'b1;
    localparam int   SETTLE_CYCLES    = 8;
    localparam int   RANDOM_ITEMS     = 400;
    localparam int   PHASE_ITEMS      = 35;
    localparam int   LONG_HOLD_CYCLES = 300;
    localparam int   MAX_REPORTS      = 40;
    localparam int   NUM_ROWS         = 20;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // one row of the directed table
    typedef struct packed {
        logic                    dir;
        logic signed [KEY_W-1:0] value;
        logic                    last;
        logic                    typed;
        t_out_item               want;
    } t_row;

    // per-item note: a hand-written result replaces the sorted one
    typedef struct packed {
        logic      typed;
        t_out_item want;
    } t_row_tag;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_ready     = 1'b0;
    t_in_item   i_item      = '0;
    logic       o_ready;
    logic       o_valid;
    t_out_item  o_item;

    // mirror of the block's state
    logic signed [KEY_W-1:0] list_keys[$];
    logic                    list_dropped = 1'b0;
    logic                    sort_desc    = 1'b0;
    t_out_item               ranked_now[$];
    t_out_item               expected_positions[$];
    t_row_tag                row_tags[$];

    bit long_hold_req   = 1'b0;
    int errors          = 0;
    int lists_closed    = 0;
    int overflow_runs   = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int random_items    = 0;
    int dir_writes      = 0;

    t_row stim_table [0:NUM_ROWS-1] = '{
        // one-key lists: position 0, final, no overflow
        '{ASCENDING,  32'sd0,        1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{ASCENDING,  KEY_MIN,       1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{ASCENDING,  KEY_MAX,       1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
        // extremes and sign boundary
        '{ASCENDING,  KEY_MAX,       1'b0, 1'b0, '0},
        '{ASCENDING,  KEY_MIN,       1'b0, 1'b0, '0},
        '{ASCENDING,  -32'sd1,       1'b0, 1'b0, '0},
        '{ASCENDING,  32'sd0,        1'b1, 1'b0, '0},
        // ties must keep arrival order
        '{ASCENDING,  32'sd5,        1'b0, 1'b0, '0},
        '{ASCENDING,  32'sd5,        1'b0, 1'b0, '0},
        '{ASCENDING,  -32'sd5,       1'b0, 1'b0, '0},
        '{ASCENDING,  32'sd5,        1'b1, 1'b0, '0},
        // same ties sorted descending
        '{DESCENDING, 32'sd5,        1'b0, 1'b0, '0},
        '{DESCENDING, -32'sd5,       1'b0, 1'b0, '0},
        '{DESCENDING, 32'sd5,        1'b0, 1'b0, '0},
        '{DESCENDING, 32'sd5,        1'b1, 1'b0, '0},
        // alternating bit patterns, then a one-key list
        '{DESCENDING, KEY_MIN,       1'b0, 1'b0, '0},
        '{DESCENDING, KEY_MAX,       1'b0, 1'b0, '0},
        '{DESCENDING, 32'h5555_5555, 1'b0, 1'b0, '0},
        '{DESCENDING, 32'hAAAA_AAAA, 1'b1, 1'b0, '0},
        '{DESCENDING, -32'sd1,       1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}}
    };

    argsort_index_sorter #(
        .MAX_ITEMS (LIST_CAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    // true when key a must come out strictly ahead of key b
    function automatic bit ranks_ahead(input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
        return sort_desc ? (a > b) : (a < b);
    endfunction

    // take one key; on the closing key, stable-sort the list into ranked_now
    function automatic void absorb_key(input t_in_item it);
        logic signed [KEY_W-1:0] keys [LIST_CAP];
        logic [POS_W-1:0]        poss [LIST_CAP];
        logic signed [KEY_W-1:0] k;
        logic [POS_W-1:0]        p;
        t_out_item               res;
        int                      n;
        int                      j;
        ranked_now.delete();
        if (list_keys.size() < LIST_CAP) list_keys.insert(list_keys.size(), it.value);
        else list_dropped = 1'b1;
        if (!it.last_in) return;
        n = list_keys.size();
        for (int i = 0; i < n; i++) begin
            keys[i] = list_keys[i];
            poss[i] = POS_W'(i);
        end
        for (int i = 1; i < n; i++) begin
            k = keys[i];
            p = poss[i];
            j = i;
            while (j > 0 && ranks_ahead(k, keys[j-1])) begin
                keys[j] = keys[j-1];
                poss[j] = poss[j-1];
                j--;
            end
            keys[j] = k;
            poss[j] = p;
        end
        for (int i = 0; i < n; i++) begin
            res.position = poss[i];
            res.last_out = (i == n - 1);
            res.overflow = list_dropped;
            ranked_now.insert(ranked_now.size(), res);
        end
        lists_closed++;
        if (list_dropped) overflow_runs++;
        list_keys.delete();
        list_dropped = 1'b0;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // prediction on accepted keys, comparison on accepted results
    always @(posedge i_clk) begin : monitor
        t_row_tag  tag;
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_we) sort_desc = i_cfg_wdata;
            if (i_valid && o_ready) begin
                tag = row_tags.pop_front();
                absorb_key(i_item);
                if (tag.typed && i_item.last_in) begin
                    expected_positions.insert(expected_positions.size(), tag.want);
                end else begin
                    foreach (ranked_now[i])
                        expected_positions.insert(expected_positions.size(), ranked_now[i]);
                end
            end
            if (o_valid && i_ready) begin
                if (expected_positions.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got position %0d",
                                 $time, o_item.position);
                end else begin
                    want = expected_positions.pop_front();
                    results_checked++;
                    if (o_item.position !== want.position)
                        report_mismatch("position", int'(want.position),
                                        int'(o_item.position));
                    if (o_item.last_out !== want.last_out)
                        report_mismatch("last_out", int'(want.last_out),
                                        int'(o_item.last_out));
                    if (o_item.overflow !== want.overflow)
                        report_mismatch("overflow", int'(want.overflow),
                                        int'(o_item.overflow));
                end
            end
        end
    end

    // result side: random stalls, calm stretches, one long hold on request
    initial begin : result_sink
        int stall_left;
        int calm_left;
        int sel;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_ready <= 1'b1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    i_ready <= 1'b1;
                end else if (sel < 85) begin
                    stall_left = $urandom_range(0, 2);
                    i_ready <= 1'b0;
                end else if (sel < 93) begin
                    stall_left = $urandom_range(10, 40);
                    i_ready <= 1'b0;
                end else begin
                    calm_left = $urandom_range(30, 80);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 95) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 75) return $urandom_range(1, 6);
        if (sel < 93) return $urandom_range(7, 20);
        return $urandom_range(21, 40);
    endfunction

    // mix of full-range, tie-prone, extreme and mid-range keys
    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        int near;
        sel = $urandom_range(0, 99);
        if (sel < 40) return $urandom;
        if (sel < 70) begin
            near = $urandom_range(0, 6);
            return near - 3;
        end
        if (sel < 85) begin
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_MIN + 1;
                3: return KEY_MAX - 1;
                4: return -1;
                default: return 0;
            endcase
        end
        near = $urandom_range(0, 2000);
        return near - 1000;
    endfunction

    // present one key and hold it until the block takes it
    task automatic offer(input logic signed [KEY_W-1:0] value, input logic last,
                         input logic typed, input t_out_item want, input int gap);
        t_in_item it;
        t_row_tag tag;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.value   = value;
        it.last_in = last;
        tag.typed  = typed;
        tag.want   = want;
        row_tags.insert(row_tags.size(), tag);
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // stop offering and wait until every expected result is out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_positions.size() != 0 || row_tags.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_direction(input logic dir);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dir;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dir_writes++;
    endtask

    task automatic send_list(input int len);
        bit calm;
        calm = ($urandom_range(0, 99) < 20);
        for (int i = 0; i < len; i++) begin
            offer(pick_key(), i == len - 1, 1'b0, '0, calm ? 0 : pick_gap());
            random_items++;
        end
    endtask

    // main sequence
    initial begin : stimulus
        logic cur_dir;
        int   phase;
        int   budget;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        cur_dir = stim_table[0].dir;
        set_direction(cur_dir);
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (stim_table[r].dir != cur_dir) begin
                cur_dir = stim_table[r].dir;
                set_direction(cur_dir);
            end
            offer(stim_table[r].value, stim_table[r].last, stim_table[r].typed,
                  stim_table[r].want, pick_gap());
        end

        // random phases, alternating direction
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            set_direction((phase % 2 == 0) ? DESCENDING : ASCENDING);
            budget = random_items + PHASE_ITEMS;
            case (phase)
                1: begin
                    // receiver holds off while lists keep coming
                    long_hold_req = 1'b1;
                    repeat (4) send_list($urandom_range(2, 5));
                end
                2: send_list(LIST_CAP);
                3: begin
                    // closing key lands on a full store
                    send_list(LIST_CAP + 1);
                    send_list(LIST_CAP + 3);
                end
                default: ;
            endcase
            while (random_items < budget) send_list(pick_len());
            phase++;
        end

        wait_drained();
        $display("Sorted %0d lists from %0d keys (%0d truncated) over %0d direction writes,",
                 lists_closed, items_sent, overflow_runs, dir_writes);
        $display("checked %0d positions, %0d errors", results_checked, errors);
        if (errors == 0 && expected_positions.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
